// File: design/move_history_gravity_table_top_defines.svh
// Assertion macros for the move history gravity table.
`ifndef MOVE_HISTORY_GRAVITY_TABLE_TOP_DEFINES_SVH
`define MOVE_HISTORY_GRAVITY_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define MHGT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MHGT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MHGT_ASSERT_IMP(lbl, ante, cons, msg)
`define MHGT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/mhgt_pkg.sv
// Shared types and constants of the move history gravity table.
package mhgt_pkg;

    localparam int SIDE_IN_W = 1;
    localparam int SQ_IN_W   = 6;
    localparam int BONUS_W   = 17;
    localparam int ENTRY_W   = 18;
    localparam int MAXH_W    = 16;
    localparam int MINH_W    = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = 35;
    localparam int DVD_W     = 36;
    localparam int DIV_STEPS = 18;
    localparam int DIV_CNT_W = 5;
    localparam int SUM_W     = 38;
    localparam int QUEUE_DEPTH = 2;

    localparam int ENTRY_MAX = 131071;
    localparam int ENTRY_MIN = -131072;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HISTORY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HISTORY = 1'b1;

    localparam logic [MAXH_W-1:0]        MAXH_RESET = 16'd16384;
    localparam logic signed [MINH_W-1:0] MINH_RESET = -17'sd16384;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [BONUS_W-1:0] clamp;
    } item_t;

endpackage

// File: design/mhgt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhgt_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/mhgt_div.sv
// Restoring divider, two quotient bits per cycle.
module mhgt_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mhgt_pkg::DVD_W-1:0]  dividend,
    input  logic [mhgt_pkg::MAXH_W-1:0] divisor,
    output logic                       done,
    output logic [mhgt_pkg::DVD_W-1:0]  quotient
);
    import mhgt_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAXH_W-1:0]    rem_reg, rem_next;
    logic [MAXH_W-1:0]    dsr_reg, dsr_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;

    logic [MAXH_W:0] r1, r1s, r2, r2s;
    logic            ge1, ge2;

    always_comb
    begin
        r1  = {rem_reg, dvd_reg[DVD_W-1]};
        ge1 = (r1 >= {1'b0, dsr_reg});
        r1s = ge1 ? (r1 - {1'b0, dsr_reg}) : r1;
        r2  = {r1s[MAXH_W-1:0], dvd_reg[DVD_W-2]};
        ge2 = (r2 >= {1'b0, dsr_reg});
        r2s = ge2 ? (r2 - {1'b0, dsr_reg}) : r2;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            dvd_next  = dividend;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-3:0], ge1, ge2};
            rem_next = r2s[MAXH_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// File: design/mhgt_back.sv
// Back end: clearing pass, table access, gravity update and result register.
module mhgt_back #(
    parameter int DEPTH = 8192,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [mhgt_pkg::MAXH_W-1:0]         maxh,
    input  logic                               q_empty,
    input  mhgt_pkg::item_t                    q_item,
    input  logic [AW-1:0]                      q_addr,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mhgt_pkg::ENTRY_W-1:0] entry_value,
    output logic                               clear_done
);
    import mhgt_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DST  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(ENTRY_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(ENTRY_MIN);

    logic [2:0]                state_reg, state_next;
    logic [AW-1:0]             clr_cnt_reg, clr_cnt_next;
    logic                      out_valid_reg, out_valid_next;
    item_t                     item_reg, item_next;
    logic [AW-1:0]             addr_reg, addr_next;
    logic signed [ENTRY_W-1:0] entry_reg, entry_next;
    logic [DVD_W-1:0]          prod_reg, prod_next;
    logic signed [ENTRY_W-1:0] res_reg, res_next;
    logic signed [ENTRY_W-1:0] out_data_reg, out_data_next;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic                div_start, div_done;
    logic [DVD_W-1:0]    div_quot;

    logic [ENTRY_W-1:0]        abs_e;
    logic [BONUS_W-1:0]        mag;
    logic [PROD_W-1:0]         prod_c;
    logic signed [SUM_W-1:0]   grav_mag, grav, nv;
    logic signed [ENTRY_W-1:0] sat_c;

    mhgt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mhgt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (maxh),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        abs_e    = entry_reg[ENTRY_W-1] ? ENTRY_W'(-entry_reg) : ENTRY_W'(entry_reg);
        mag      = item_reg.clamp[BONUS_W-1] ? BONUS_W'(-item_reg.clamp)
                                             : BONUS_W'(item_reg.clamp);
        prod_c   = PROD_W'(abs_e) * PROD_W'(mag);
        grav_mag = SUM_W'($signed({1'b0, div_quot}));
        if (maxh == '0)
        begin
            grav = '0;
        end
        else if (entry_reg[ENTRY_W-1])
        begin
            grav = -grav_mag;
        end
        else
        begin
            grav = grav_mag;
        end
        nv = SUM_W'(entry_reg) + SUM_W'(item_reg.clamp) - grav;
        if (nv > SAT_HI)
        begin
            sat_c = ENTRY_W'(ENTRY_MAX);
        end
        else if (nv < SAT_LO)
        begin
            sat_c = ENTRY_W'(ENTRY_MIN);
        end
        else
        begin
            sat_c = $signed(nv[ENTRY_W-1:0]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        addr_next      = addr_reg;
        entry_next     = entry_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = res_reg;
        ram_re         = 1'b0;
        ram_raddr      = q_addr;
        div_start      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    ram_re     = 1'b1;
                    item_next  = q_item;
                    addr_next  = q_addr;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                entry_next = $signed(ram_rdata);
                res_next   = $signed(ram_rdata);
                state_next = (item_reg.action == ACT_READ) ? S_FIN : S_MUL;
            end
            S_MUL:
            begin
                prod_next  = DVD_W'(prod_c);
                state_next = (maxh == '0) ? S_SUM : S_DST;
            end
            S_DST:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                res_next   = sat_c;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ram_we         = (item_reg.action == ACT_UPDATE);
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        addr_reg     <= addr_next;
        entry_reg    <= entry_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid   = out_valid_reg;
    assign entry_value = out_data_reg;
    assign clear_done  = (state_reg != S_CLR);

endmodule

// File: design/mhgt_queue.sv
// Small FIFO between front and back end.
module mhgt_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));

endmodule

// File: design/mhgt_front.sv
// Front end: item intake, address folding and bonus clamp.
module mhgt_front #(
    parameter int SQUARES = 64,
    parameter int SIDES = 2,
    localparam int AW = $clog2(SIDES * SQUARES * SQUARES)
) (
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [mhgt_pkg::SIDE_IN_W-1:0]      side,
    input  logic [mhgt_pkg::SQ_IN_W-1:0]        from_square,
    input  logic [mhgt_pkg::SQ_IN_W-1:0]        to_square,
    input  logic signed [mhgt_pkg::BONUS_W-1:0] bonus,
    input  logic [mhgt_pkg::MAXH_W-1:0]         maxh,
    input  logic signed [mhgt_pkg::MINH_W-1:0]  minh,
    input  logic                               q_full,
    input  logic                               clear_done,
    output logic                               push,
    output mhgt_pkg::item_t                    push_item,
    output logic [AW-1:0]                      push_addr
);
    import mhgt_pkg::*;

    localparam int SQW = $clog2(SQUARES);
    localparam int SDW = (SIDES > 1) ? $clog2(SIDES) : 1;
    localparam int SQ_N = 2 ** SQ_IN_W;
    localparam int SD_N = 2 ** SIDE_IN_W;

    logic [SQW-1:0] sq_tab [SQ_N];
    logic [SDW-1:0] sd_tab [SD_N];

    for (genvar g = 0; g < SQ_N; g++)
    begin : g_sq
        assign sq_tab[g] = SQW'(g % SQUARES);
    end

    for (genvar g = 0; g < SD_N; g++)
    begin : g_sd
        assign sd_tab[g] = SDW'(g % SIDES);
    end

    logic signed [BONUS_W-1:0] maxh_s;
    logic signed [BONUS_W-1:0] clamp_c;

    always_comb
    begin
        maxh_s = $signed({1'b0, maxh});
        if (bonus < minh)
        begin
            clamp_c = minh;
        end
        else if (bonus > maxh_s)
        begin
            clamp_c = maxh_s;
        end
        else
        begin
            clamp_c = bonus;
        end
    end

    assign in_ready         = !q_full && clear_done;
    assign push             = in_valid && in_ready;
    assign push_item.action = action;
    assign push_item.clamp  = clamp_c;
    assign push_addr = AW'(sd_tab[side]) * AW'(SQUARES * SQUARES)
                     + AW'(sq_tab[from_square]) * AW'(SQUARES)
                     + AW'(sq_tab[to_square]);

endmodule

// File: design/move_history_gravity_table_top.sv
// Reads skip the multiply and divide steps; updates wait on the two-bit-per-cycle
// divider (18 steps), which is skipped when max_history is zero. The back end takes
// one item at a time; a two-entry queue takes items meanwhile.
// After reset a clearing pass writes zero over SIDES*SQUARES*SQUARES entries,
// one a cycle (8192 by default), with in_ready low; config resets apply at once.
`include "move_history_gravity_table_top_defines.svh"

module move_history_gravity_table_top #(
    parameter int SQUARES = 64,
    parameter int SIDES = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic [mhgt_pkg::SIDE_IN_W-1:0]      side,
    input  logic [mhgt_pkg::SQ_IN_W-1:0]        from_square,
    input  logic [mhgt_pkg::SQ_IN_W-1:0]        to_square,
    input  logic signed [mhgt_pkg::BONUS_W-1:0] bonus,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [mhgt_pkg::ENTRY_W-1:0] entry_value,
    input  logic                               cfg_we,
    input  logic [mhgt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mhgt_pkg::CFG_W-1:0]          cfg_data
);
    import mhgt_pkg::*;

    localparam int DEPTH = SIDES * SQUARES * SQUARES;
    localparam int AW = $clog2(DEPTH);
    localparam int QW = $bits(item_t) + AW;

    logic [MAXH_W-1:0]        maxh_reg, maxh_next;
    logic signed [MINH_W-1:0] minh_reg, minh_next;

    always_comb
    begin
        maxh_next = maxh_reg;
        minh_next = minh_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_HISTORY: maxh_next = cfg_data[MAXH_W-1:0];
                CFG_MIN_HISTORY: minh_next = $signed(cfg_data[MINH_W-1:0]);
                default:         maxh_next = maxh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxh_reg <= MAXH_RESET;
            minh_reg <= MINH_RESET;
        end
        else
        begin
            maxh_reg <= maxh_next;
            minh_reg <= minh_next;
        end
    end

    logic          q_push, q_pop, q_empty, q_full, clear_done;
    item_t         push_item, q_item;
    logic [AW-1:0] push_addr, q_addr;
    logic [QW-1:0] q_wdata, q_rdata;

    mhgt_front #(
        .SQUARES (SQUARES),
        .SIDES   (SIDES)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .side        (side),
        .from_square (from_square),
        .to_square   (to_square),
        .bonus       (bonus),
        .maxh        (maxh_reg),
        .minh        (minh_reg),
        .q_full      (q_full),
        .clear_done  (clear_done),
        .push        (q_push),
        .push_item   (push_item),
        .push_addr   (push_addr)
    );

    assign q_wdata = {push_item, push_addr};

    mhgt_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    assign q_item = q_rdata[QW-1:AW];
    assign q_addr = q_rdata[AW-1:0];

    mhgt_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .maxh        (maxh_reg),
        .q_empty     (q_empty),
        .q_item      (q_item),
        .q_addr      (q_addr),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .entry_value (entry_value),
        .clear_done  (clear_done)
    );

    `MHGT_ASSERT_IMP(a_no_intake_in_clear, !clear_done, !in_ready, "item taken during clear")
    `MHGT_ASSERT_NXT(a_clear_once, clear_done, clear_done, "clearing pass restarted")
    `MHGT_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full, "queue overflow")

endmodule
